// ===== rtl/glyph_bitmap_pixel_expander_assert.svh =====
// Assertion macros of the glyph bitmap pixel expander RTL.
// Included by gbpe_serializer, which checks its own logic; needs no other file.
`ifndef GLYPH_BITMAP_PIXEL_EXPANDER_ASSERT_SVH
`define GLYPH_BITMAP_PIXEL_EXPANDER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is high.
`define GBPE_ASSERT_IMPLY(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("gbpe assertion failed");

// Next-cycle implication, disabled while reset is high.
`define GBPE_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("gbpe assertion failed");

`else

`define GBPE_ASSERT_IMPLY(label, clk, rst, cond, expr)
`define GBPE_ASSERT_NEXT(label, clk, rst, cond, expr)

`endif

`endif

// ===== rtl/gbpe_pkg.sv =====
// Types and constants of the glyph bitmap pixel expander.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package gbpe_pkg;

   localparam int COORD_W         = 11;
   localparam int HEIGHT_W        = 6;
   localparam int BYTE_W          = 8;
   localparam int COLOR_W         = 16;
   localparam int PIXELS_PER_BYTE = 8;
   localparam int PIX_IDX_W       = $clog2(PIXELS_PER_BYTE);

   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 40;
   localparam int RSP_PAD_W   = RSP_TDATA_W - (2 * COORD_W + COLOR_W);
   localparam int CSR_INDEX_W = 1;

   // Command codes carried in req_tuser.
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_BYTE  = 1'b1;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_TEXT_COLOR = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BACK_COLOR = 1'd1;

   localparam logic [COLOR_W-1:0] TEXT_COLOR_RESET = 16'hFFFF;
   localparam logic [COLOR_W-1:0] BACK_COLOR_RESET = 16'h0000;

   // Supported glyph heights.
   localparam logic [HEIGHT_W-1:0] GLYPH_H16 = 6'd16;
   localparam logic [HEIGHT_W-1:0] GLYPH_H24 = 6'd24;
   localparam logic [HEIGHT_W-1:0] GLYPH_H32 = 6'd32;

   typedef struct packed {
      logic                command;
      logic [COORD_W-1:0]  start_x;
      logic [COORD_W-1:0]  start_y;
      logic [HEIGHT_W-1:0] glyph_size;
      logic                overlay;
      logic                clip_enable;
      logic [BYTE_W-1:0]   glyph_byte;
   } gbpe_item_type;

   typedef struct packed {
      logic [COORD_W-1:0]  cursor_x;
      logic [COORD_W-1:0]  cursor_y;
      logic [COORD_W-1:0]  column_top;
      logic [HEIGHT_W-1:0] height_held;
      logic                overlay_held;
      logic                clip_held;
      logic                drawing_active;
   } gbpe_state_type;

   // Pixel writes of one glyph byte; bit i of a mask is the i-th pixel down.
   typedef struct packed {
      logic [PIXELS_PER_BYTE-1:0] write_mask;
      logic [PIXELS_PER_BYTE-1:0] set_bits;
      logic [COORD_W-1:0]         x;
      logic [COORD_W-1:0]         y;
   } gbpe_burst_type;

endpackage

// ===== rtl/gbpe_expand.sv =====
// Per-item logic: loads the glyph state on a start command and expands a
// glyph byte into a burst of pixel writes. Depends on gbpe_pkg.
`timescale 1ns / 1ps

module gbpe_expand
   import gbpe_pkg::*;
#(
   parameter int SCREEN_WIDTH  = 800,
   parameter int SCREEN_HEIGHT = 480
) (
   input  gbpe_item_type  item,
   input  gbpe_state_type state,
   output gbpe_state_type state_next,
   output gbpe_burst_type burst
);

   localparam logic [COORD_W-1:0] WIDTH_LIM  = COORD_W'(SCREEN_WIDTH);
   localparam logic [COORD_W-1:0] HEIGHT_LIM = COORD_W'(SCREEN_HEIGHT);

   logic [COORD_W-1:0]         row_next [PIXELS_PER_BYTE];
   logic [PIXELS_PER_BYTE-1:0] clip_hit;
   logic [PIXELS_PER_BYTE-1:0] wrap_hit;
   logic [PIXELS_PER_BYTE-1:0] set_bits;
   logic [COORD_W-1:0]         col_next;

   // Row after each bit and the two ways a byte can end there.
   always_comb begin
      for (int i = 0; i < PIXELS_PER_BYTE; i++) begin
         row_next[i] = state.cursor_y + COORD_W'(i + 1);
         clip_hit[i] = state.clip_held && (row_next[i] >= HEIGHT_LIM);
         wrap_hit[i] = ((row_next[i] - state.column_top) == COORD_W'(state.height_held));
         set_bits[i] = item.glyph_byte[BYTE_W-1-i];
      end
   end

   assign col_next = state.cursor_x + COORD_W'(1);

   // Walk the bits top down; the first clip or column wrap ends the byte.
   always_comb begin
      logic alive;
      alive            = 1'b1;
      state_next       = state;
      burst.write_mask = '0;
      burst.set_bits   = set_bits;
      burst.x          = state.cursor_x;
      burst.y          = state.cursor_y;
      if (item.command == CMD_START) begin
         state_next.cursor_x       = item.start_x;
         state_next.cursor_y       = item.start_y;
         state_next.column_top     = item.start_y;
         state_next.height_held    = item.glyph_size;
         state_next.overlay_held   = item.overlay;
         state_next.clip_held      = item.clip_enable;
         state_next.drawing_active = (item.glyph_size == GLYPH_H16) ||
                                     (item.glyph_size == GLYPH_H24) ||
                                     (item.glyph_size == GLYPH_H32);
      end else if (state.drawing_active) begin
         state_next.cursor_y = state.cursor_y + COORD_W'(PIXELS_PER_BYTE);
         for (int i = 0; i < PIXELS_PER_BYTE; i++) begin
            if (alive) begin
               burst.write_mask[i] = set_bits[i] | state.overlay_held;
               if (clip_hit[i]) begin
                  state_next.drawing_active = 1'b0;
                  state_next.cursor_y       = row_next[i];
                  alive                     = 1'b0;
               end else if (wrap_hit[i]) begin
                  state_next.cursor_y = state.column_top;
                  state_next.cursor_x = col_next;
                  if (state.clip_held && (col_next >= WIDTH_LIM)) begin
                     state_next.drawing_active = 1'b0;
                  end
                  alive = 1'b0;
               end
            end
         end
      end
   end

endmodule

// ===== rtl/gbpe_serializer.sv =====
// Burst register and pixel serializer: holds the writes of one glyph byte
// and hands them out one transfer per cycle while rsp_tready is high.
// Depends on gbpe_pkg and the assertion macro header.
`timescale 1ns / 1ps

`include "glyph_bitmap_pixel_expander_assert.svh"

module gbpe_serializer
   import gbpe_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  gbpe_burst_type      burst_load,
   input  logic [COLOR_W-1:0]  text_color,
   input  logic [COLOR_W-1:0]  back_color,
   input  logic                rsp_tready,
   output logic                rsp_tvalid,
   output logic                rsp_tlast,
   output logic [COORD_W-1:0]  pixel_x,
   output logic [COORD_W-1:0]  pixel_y,
   output logic [COLOR_W-1:0]  pixel_color,
   output logic                burst_free
);

   logic [PIXELS_PER_BYTE-1:0] mask_ff, mask_in;
   gbpe_burst_type             data_ff;
   logic [PIXELS_PER_BYTE-1:0] pick;
   logic [PIX_IDX_W-1:0]       idx;
   logic                       xfer;

   // Lowest pending write goes out first.
   assign pick = mask_ff & (~mask_ff + PIXELS_PER_BYTE'(1));

   always_comb begin
      idx = '0;
      for (int i = PIXELS_PER_BYTE - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            idx = PIX_IDX_W'(i);
         end
      end
   end

   assign rsp_tvalid  = |mask_ff;
   assign rsp_tlast   = ((mask_ff & ~pick) == '0);
   assign pixel_x     = data_ff.x;
   assign pixel_y     = data_ff.y + COORD_W'(idx);
   assign pixel_color = data_ff.set_bits[idx] ? text_color : back_color;
   assign xfer        = rsp_tvalid && rsp_tready;
   assign burst_free  = !rsp_tvalid || (rsp_tlast && rsp_tready);

   // Pending mask: loaded with a new burst, one bit retired per transfer.
   always_comb begin
      if (load) begin
         mask_in = burst_load.write_mask;
      end else if (xfer) begin
         mask_in = mask_ff & ~pick;
      end else begin
         mask_in = mask_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= burst_load;
      end
   end

   // A new burst never overwrites writes that are still pending.
   `GBPE_ASSERT_IMPLY(a_load_when_free, clock, reset, load, burst_free)
   // A burst stays visible until its final write has been taken.
   `GBPE_ASSERT_NEXT(a_burst_continues, clock, reset, xfer && !rsp_tlast, rsp_tvalid)
   // With no new burst, the final transfer leaves the output empty.
   `GBPE_ASSERT_NEXT(a_burst_drains, clock, reset, xfer && rsp_tlast && !load, !rsp_tvalid)

endmodule

// ===== rtl/glyph_bitmap_pixel_expander.sv =====
// Glyph bitmap pixel expander: a glyph byte is registered, expanded in one
// pass into a burst of up to eight pixel writes, and serialized.
// A byte is held in the input register, then its writes are loaded into the
// serializer's burst register, which the next byte waits on until the final
// write is taken. Pixel writes go out one per cycle while rsp_tready is high.
// Reset (synchronous): cursor and glyph flags cleared, text color white, back color black.
`timescale 1ns / 1ps

module glyph_bitmap_pixel_expander
   import gbpe_pkg::*;
#(
   parameter int SCREEN_WIDTH  = 800,
   parameter int SCREEN_HEIGHT = 480
) (
   input  logic                   clock,
   input  logic                   reset,
   // Input item channel.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // From bit 0: start_x, start_y, glyph_size, overlay, clip_enable,
   // glyph_byte, zero fill.
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // command
   input  logic                   req_tuser,
   // Pixel write channel.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // From bit 0: pixel_x, pixel_y, pixel_color, zero fill.
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tlast,
   // Register write channel.
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [COLOR_W-1:0]     csr_data
);

   gbpe_item_type      item_in, item_ff;
   logic               item_valid_ff, item_valid_in;
   gbpe_state_type     state_ff, state_next;
   gbpe_burst_type     burst;
   logic [COLOR_W-1:0] text_color_ff, back_color_ff;
   logic               burst_free;
   logic               advance;
   logic               load;
   logic [COORD_W-1:0] pixel_x, pixel_y;
   logic [COLOR_W-1:0] pixel_color;

   // Unpack the input transfer.
   always_comb begin
      item_in.command     = req_tuser;
      item_in.start_x     = req_tdata[10:0];
      item_in.start_y     = req_tdata[21:11];
      item_in.glyph_size  = req_tdata[27:22];
      item_in.overlay     = req_tdata[28];
      item_in.clip_enable = req_tdata[29];
      item_in.glyph_byte  = req_tdata[37:30];
   end

   // A start always moves on; a byte waits until the burst register frees.
   assign advance    = item_valid_ff && ((item_ff.command == CMD_START) || burst_free);
   assign load       = advance && (item_ff.command == CMD_BYTE);
   assign req_tready = !item_valid_ff || advance;

   // Input register.
   assign item_valid_in = (req_tvalid && req_tready) || (item_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= item_in;
      end
   end

   // Glyph state advances with each item that leaves the input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_next;
      end
   end

   // Color registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         text_color_ff <= TEXT_COLOR_RESET;
         back_color_ff <= BACK_COLOR_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TEXT_COLOR: begin
               text_color_ff <= csr_data;
            end
            CSR_BACK_COLOR: begin
               back_color_ff <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   gbpe_expand #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_expand (
      .item       (item_ff),
      .state      (state_ff),
      .state_next (state_next),
      .burst      (burst)
   );

   gbpe_serializer u_serializer (
      .clock       (clock),
      .reset       (reset),
      .load        (load),
      .burst_load  (burst),
      .text_color  (text_color_ff),
      .back_color  (back_color_ff),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tlast   (rsp_tlast),
      .pixel_x     (pixel_x),
      .pixel_y     (pixel_y),
      .pixel_color (pixel_color),
      .burst_free  (burst_free)
   );

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, pixel_color, pixel_y, pixel_x};

endmodule
